// ===== hdl/usb_control_endpoint_sequencer_core_assert.svh =====
// ----------------------------------------------------------------------------
// USB control endpoint sequencer assertion macros
// Shared concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef USB_CONTROL_ENDPOINT_SEQUENCER_CORE_ASSERT_SVH
`define USB_CONTROL_ENDPOINT_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USBCEP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USBCEP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/usbcep_pkg.sv =====
// ----------------------------------------------------------------------------
// USB control endpoint sequencer package
// Event codes, decoded command type, stage and device state codes, result type.
// ----------------------------------------------------------------------------
package usbcep_pkg;

  localparam logic [1:0] MODE_BUS_RESET = 2'd0;
  localparam logic [1:0] MODE_SETUP     = 2'd1;
  localparam logic [1:0] MODE_POLL      = 2'd2;
  localparam logic [1:0] MODE_IN_DONE   = 2'd3;

  localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
  localparam logic [7:0] REQ_HID_SET_IDLE   = 8'h0A;

  localparam logic [6:0] KIND_STD_DEVICE    = 7'h00;
  localparam logic [6:0] KIND_STD_INTERFACE = 7'h01;
  localparam logic [6:0] KIND_CLASS_IFACE   = 7'h21;

  localparam logic [7:0] DESC_DEVICE     = 8'h01;
  localparam logic [7:0] DESC_CONFIG     = 8'h02;
  localparam logic [7:0] DESC_HID_REPORT = 8'h22;

  localparam logic [1:0] SRC_DEVICE     = 2'd0;
  localparam logic [1:0] SRC_CONFIG     = 2'd1;
  localparam logic [1:0] SRC_HID_REPORT = 2'd2;

  localparam logic [2:0] STAGE_SETUP       = 3'd0;
  localparam logic [2:0] STAGE_DATA_IN     = 3'd1;
  localparam logic [2:0] STAGE_DATA_IDLE   = 3'd2;
  localparam logic [2:0] STAGE_DATA_ZERO   = 3'd3;
  localparam logic [2:0] STAGE_STATUS_OUT  = 3'd4;
  localparam logic [2:0] STAGE_STATUS_IN   = 3'd5;

  localparam logic [1:0] DEV_DEFAULT    = 2'd0;
  localparam logic [1:0] DEV_ADDRESSED  = 2'd1;
  localparam logic [1:0] DEV_CONFIGURED = 2'd2;

  localparam logic [6:0] MPS_MIN = 7'd8;
  localparam logic [6:0] MPS_MAX = 7'd64;

  localparam logic [1:0] CFG_MAX_PACKET  = 2'd0;
  localparam logic [1:0] CFG_DEVICE_LEN  = 2'd1;
  localparam logic [1:0] CFG_CONFIG_LEN  = 2'd2;
  localparam logic [1:0] CFG_REPORT_LEN  = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET,
    CMD_READ,
    CMD_SET_ADDR,
    CMD_SET_CONFIG,
    CMD_STATUS,
    CMD_POLL,
    CMD_IN_DONE
  } cmd_e;

  typedef struct packed {
    cmd_e        kind;
    logic [1:0]  source;
    logic [15:0] length;
    logic [7:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  control_stage;
    logic [7:0]  active_config;
    logic [1:0]  dev_status;
    logic [6:0]  address_value;
    logic        address_write;
    logic [6:0]  packet_length;
    logic [15:0] packet_offset;
    logic [1:0]  packet_source;
    logic        send_packet;
  } result_t;

endpackage

// ===== hdl/usbcep_front.sv =====
// ----------------------------------------------------------------------------
// USB control endpoint sequencer front end
// Decodes each event and setup packet into a command with a clamped length.
// ----------------------------------------------------------------------------
module usbcep_front (
  input  logic [1:0]      mode_i,
  input  logic [7:0]      request_type_i,
  input  logic [7:0]      request_code_i,
  input  logic [15:0]     request_value_i,
  input  logic [15:0]     request_length_i,
  input  logic [7:0]      device_desc_length_i,
  input  logic [15:0]     config_desc_length_i,
  input  logic [15:0]     report_desc_length_i,
  output usbcep_pkg::cmd_t cmd_o
);
  import usbcep_pkg::*;

  logic [6:0]  kind;
  logic [7:0]  dtype;
  cmd_e        cmd_kind;
  logic [1:0]  src;
  logic [7:0]  cmd_value;
  logic [15:0] desc_len;
  logic [15:0] clamped_len;

  assign kind  = request_type_i[6:0];
  assign dtype = request_value_i[15:8];

  always_comb begin
    cmd_kind  = CMD_NONE;
    src       = SRC_DEVICE;
    cmd_value = request_value_i[7:0];
    case (mode_i)
      MODE_BUS_RESET: cmd_kind = CMD_RESET;
      MODE_SETUP: begin
        if (kind == KIND_STD_DEVICE) begin
          if (request_code_i == REQ_GET_DESCRIPTOR) begin
            if (dtype == DESC_DEVICE) begin
              cmd_kind = CMD_READ;
              src      = SRC_DEVICE;
            end else if (dtype == DESC_CONFIG) begin
              cmd_kind = CMD_READ;
              src      = SRC_CONFIG;
            end
          end else if (request_code_i == REQ_SET_ADDRESS) begin
            cmd_kind  = CMD_SET_ADDR;
            cmd_value = {1'b0, request_value_i[6:0]};
          end else if (request_code_i == REQ_SET_CONFIG) begin
            cmd_kind = CMD_SET_CONFIG;
          end
        end else if (kind == KIND_CLASS_IFACE) begin
          if (request_code_i == REQ_HID_SET_IDLE) begin
            cmd_kind = CMD_STATUS;
          end
        end else if (kind == KIND_STD_INTERFACE) begin
          if (request_code_i == REQ_GET_DESCRIPTOR && dtype == DESC_HID_REPORT) begin
            cmd_kind = CMD_READ;
            src      = SRC_HID_REPORT;
          end
        end
      end
      MODE_POLL: cmd_kind = CMD_POLL;
      default:   cmd_kind = CMD_IN_DONE;
    endcase
  end

  always_comb begin
    case (src)
      SRC_DEVICE: desc_len = {8'd0, device_desc_length_i};
      SRC_CONFIG: desc_len = config_desc_length_i;
      default:    desc_len = report_desc_length_i;
    endcase
  end

  assign clamped_len = (request_length_i < desc_len) ? request_length_i : desc_len;

  assign cmd_o = '{kind: cmd_kind, source: src, length: clamped_len, value: cmd_value};

endmodule

// ===== hdl/usbcep_queue.sv =====
// ----------------------------------------------------------------------------
// USB control endpoint sequencer command queue
// Small register queue that decouples the decoder from the executor.
// ----------------------------------------------------------------------------
`include "usb_control_endpoint_sequencer_core_assert.svh"

module usbcep_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  usbcep_pkg::cmd_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output usbcep_pkg::cmd_t head_o
);
  import usbcep_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `USBCEP_ASSERT_IMP(a_count_bound, 1'b1, count_q <= FullCnt, "queue count above depth")
  `USBCEP_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o, "pop from empty queue")
  `USBCEP_ASSERT_NXT(a_push_grows, push_i && !pop_i, count_q == $past(count_q) + 1'b1,
                     "push did not grow queue")

endmodule

// ===== hdl/usbcep_back.sv =====
// ----------------------------------------------------------------------------
// USB control endpoint sequencer back end
// Executes commands against the transfer state and registers one result each.
// ----------------------------------------------------------------------------
`include "usb_control_endpoint_sequencer_core_assert.svh"

module usbcep_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  usbcep_pkg::cmd_t    cmd_i,
  output logic                cmd_pop_o,
  input  logic [6:0]          max_packet_size_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output usbcep_pkg::result_t out_data_o
);
  import usbcep_pkg::*;

  logic [2:0]  stage_q, stage_d;
  logic [15:0] remain_q, remain_d;
  logic [15:0] offset_q, offset_d;
  logic [1:0]  source_q, source_d;
  logic [1:0]  dev_state_q, dev_state_d;
  logic [7:0]  config_q, config_d;
  logic [6:0]  addr_q, addr_d;
  logic        out_valid_q;
  result_t     out_data_q;
  result_t     res;
  logic [6:0]  eff_max;
  logic [6:0]  chunk;
  logic        fire;

  assign fire      = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cmd_pop_o = fire;

  always_comb begin
    if (max_packet_size_i < MPS_MIN) begin
      eff_max = MPS_MIN;
    end else if (max_packet_size_i > MPS_MAX) begin
      eff_max = MPS_MAX;
    end else begin
      eff_max = max_packet_size_i;
    end
  end

  assign chunk = (remain_q < {9'd0, eff_max}) ? remain_q[6:0] : eff_max;

  always_comb begin
    stage_d     = stage_q;
    remain_d    = remain_q;
    offset_d    = offset_q;
    source_d    = source_q;
    dev_state_d = dev_state_q;
    config_d    = config_q;
    addr_d      = addr_q;
    res         = '0;
    case (cmd_i.kind)
      CMD_RESET: begin
        stage_d           = STAGE_SETUP;
        remain_d          = '0;
        offset_d          = '0;
        source_d          = SRC_DEVICE;
        dev_state_d       = DEV_DEFAULT;
        config_d          = '0;
        addr_d            = '0;
        res.address_write = 1'b1;
      end
      CMD_READ: begin
        source_d = cmd_i.source;
        remain_d = cmd_i.length;
        offset_d = '0;
        stage_d  = STAGE_DATA_IN;
      end
      CMD_SET_ADDR: begin
        addr_d            = cmd_i.value[6:0];
        res.address_write = 1'b1;
        dev_state_d       = DEV_ADDRESSED;
        stage_d           = STAGE_STATUS_IN;
      end
      CMD_SET_CONFIG: begin
        config_d    = cmd_i.value;
        dev_state_d = DEV_CONFIGURED;
        stage_d     = STAGE_STATUS_IN;
      end
      CMD_STATUS: stage_d = STAGE_STATUS_IN;
      CMD_POLL: begin
        case (stage_q)
          STAGE_DATA_IN: begin
            res.send_packet   = 1'b1;
            res.packet_source = source_q;
            res.packet_offset = offset_q;
            res.packet_length = chunk;
            remain_d          = remain_q - {9'd0, chunk};
            offset_d          = offset_q + {9'd0, chunk};
            if (remain_d != '0) begin
              stage_d = STAGE_DATA_IDLE;
            end else if (chunk == eff_max) begin
              stage_d = STAGE_DATA_ZERO;
            end else begin
              stage_d = STAGE_STATUS_OUT;
            end
          end
          STAGE_STATUS_OUT: stage_d = STAGE_SETUP;
          STAGE_STATUS_IN: begin
            res.send_packet   = 1'b1;
            res.packet_source = source_q;
            res.packet_offset = offset_q;
            stage_d           = STAGE_SETUP;
          end
          default: stage_d = stage_q;
        endcase
      end
      CMD_IN_DONE: begin
        if (remain_q != '0) begin
          stage_d = STAGE_DATA_IN;
        end else if (stage_q == STAGE_DATA_ZERO) begin
          res.send_packet   = 1'b1;
          res.packet_source = source_q;
          res.packet_offset = offset_q;
          stage_d           = STAGE_STATUS_OUT;
        end
      end
      default: stage_d = stage_q;
    endcase
    res.address_value = addr_d;
    res.dev_status    = dev_state_d;
    res.active_config = config_d;
    res.control_stage = stage_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q     <= STAGE_SETUP;
      remain_q    <= '0;
      offset_q    <= '0;
      source_q    <= SRC_DEVICE;
      dev_state_q <= DEV_DEFAULT;
      config_q    <= '0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        stage_q     <= stage_d;
        remain_q    <= remain_d;
        offset_q    <= offset_d;
        source_q    <= source_d;
        dev_state_q <= dev_state_d;
        config_q    <= config_d;
        addr_q      <= addr_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `USBCEP_ASSERT_IMP(a_stage_legal, 1'b1, stage_q <= STAGE_STATUS_IN, "illegal control stage")
  `USBCEP_ASSERT_IMP(a_len_bound, out_valid_q, out_data_q.packet_length <= MPS_MAX,
                     "packet longer than 64 bytes")
  `USBCEP_ASSERT_IMP(a_reset_addr,
                     out_valid_q && out_data_q.address_write &&
                     out_data_q.dev_status == DEV_DEFAULT,
                     out_data_q.address_value == 7'd0, "bus reset wrote nonzero address")

endmodule

// ===== hdl/usb_control_endpoint_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// USB control endpoint sequencer core
// Endpoint zero control transfer sequencer with a decoder, queue and executor.
// ----------------------------------------------------------------------------
// Each accepted event gives exactly one result word after passing the command
// queue and the output register. One event per cycle is sustained while the
// output is taken: the decoder writes the queue, and the executor updates the
// transfer state and fills the output register whenever it is empty or taken.
// Input tuser carries the event kind; configuration writes take effect at once
// and are expected only while no event is in flight.
module usb_control_endpoint_sequencer_core #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // request_type, request_code, request_value, request_length
  input  logic [47:0] s_axis_tdata_i,
  // mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // send_packet, packet_source, packet_offset, packet_length, address_write,
  // address_value, dev_status, active_config, control_stage, zero pad
  output logic [47:0] m_axis_tdata_o
);
  import usbcep_pkg::*;

  logic [6:0]  max_packet_q;
  logic [7:0]  device_len_q;
  logic [15:0] config_len_q;
  logic [15:0] report_len_q;
  cmd_t        front_cmd;
  cmd_t        head_cmd;
  logic        q_full;
  logic        q_empty;
  logic        q_pop;
  logic        push;
  result_t     result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packet_q <= 7'd64;
      device_len_q <= 8'd18;
      config_len_q <= 16'd34;
      report_len_q <= 16'd52;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_MAX_PACKET: max_packet_q <= cfg_wdata_i[6:0];
        CFG_DEVICE_LEN: device_len_q <= cfg_wdata_i[7:0];
        CFG_CONFIG_LEN: config_len_q <= cfg_wdata_i;
        CFG_REPORT_LEN: report_len_q <= cfg_wdata_i;
        default:        max_packet_q <= max_packet_q;
      endcase
    end
  end

  usbcep_front u_front (
    .mode_i               (s_axis_tuser_i),
    .request_type_i       (s_axis_tdata_i[7:0]),
    .request_code_i       (s_axis_tdata_i[15:8]),
    .request_value_i      (s_axis_tdata_i[31:16]),
    .request_length_i     (s_axis_tdata_i[47:32]),
    .device_desc_length_i (device_len_q),
    .config_desc_length_i (config_len_q),
    .report_desc_length_i (report_len_q),
    .cmd_o                (front_cmd)
  );

  assign s_axis_tready_o = !q_full;
  assign push            = s_axis_tvalid_i && !q_full;

  usbcep_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  usbcep_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_valid_i       (!q_empty),
    .cmd_i             (head_cmd),
    .cmd_pop_o         (q_pop),
    .max_packet_size_i (max_packet_q),
    .out_valid_o       (m_axis_tvalid_o),
    .out_ready_i       (m_axis_tready_i),
    .out_data_o        (result)
  );

  assign m_axis_tdata_o = {1'b0, result};

endmodule
